[rtl/core/tdpzp_pkg.sv]
// ----------------------------------------------------------------------------
// tdpzp_pkg
// Shared types and constants of the int8 tile dot product unit.
// ----------------------------------------------------------------------------
package tdpzp_pkg;

   localparam int LANES       = 4;
   localparam int OPND_W      = 7;
   localparam int PROD_W      = 2 * OPND_W;
   localparam int DATA_W      = 32;
   localparam int ZP_W        = 8;
   localparam int SLOT_W      = 3;
   localparam int ROW_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int DEF_ROWS    = 4;
   localparam int DEF_COLS    = 4;

   localparam logic KIND_SLICE = 1'b0;
   localparam logic KIND_SUM   = 1'b1;

   typedef logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_grid_type;

   typedef struct packed {
      logic                is_sum;
      logic                emit;
      logic [SLOT_W-1:0]   slot;
      logic [DATA_W-1:0]   value;
      prod_grid_type       prod;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic load;
   } back_stat_type;

endpackage

[rtl/core/tdpzp_if.sv]
// ----------------------------------------------------------------------------
// tdpzp_req_if / tdpzp_rsp_if
// Valid/ready channels for operand and sum items and for result rows.
// ----------------------------------------------------------------------------
interface tdpzp_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic signed [6:0] act0;
   logic signed [6:0] act1;
   logic signed [6:0] act2;
   logic signed [6:0] act3;
   logic signed [6:0] wgt0;
   logic signed [6:0] wgt1;
   logic signed [6:0] wgt2;
   logic signed [6:0] wgt3;
   logic signed [31:0] sum_value;
   logic [2:0]  sum_slot;
   logic        last;

   modport source (output valid, kind, act0, act1, act2, act3, wgt0, wgt1, wgt2, wgt3,
                   sum_value, sum_slot, last, input ready);
   modport sink (input valid, kind, act0, act1, act2, act3, wgt0, wgt1, wgt2, wgt3,
                 sum_value, sum_slot, last, output ready);
endinterface

interface tdpzp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  row_index;
   logic signed [31:0] out0;
   logic signed [31:0] out1;
   logic signed [31:0] out2;
   logic signed [31:0] out3;
   logic        row_last;

   modport source (output valid, row_index, out0, out1, out2, out3, row_last, input ready);
   modport sink (input valid, row_index, out0, out1, out2, out3, row_last, output ready);
endinterface

[rtl/core/tdpzp_front.sv]
// ----------------------------------------------------------------------------
// tdpzp_front
// Classify an incoming item and form the 4x4 operand products.
// ----------------------------------------------------------------------------
module tdpzp_front (
   input  logic                              kind,
   input  logic signed [tdpzp_pkg::OPND_W-1:0] act [tdpzp_pkg::LANES],
   input  logic signed [tdpzp_pkg::OPND_W-1:0] wgt [tdpzp_pkg::LANES],
   input  logic [tdpzp_pkg::DATA_W-1:0]      sum_value,
   input  logic [tdpzp_pkg::SLOT_W-1:0]      sum_slot,
   input  logic                              last,
   output tdpzp_pkg::entry_type              entry
);

   logic signed [tdpzp_pkg::PROD_W-1:0] prod [tdpzp_pkg::LANES][tdpzp_pkg::LANES];

   always_comb begin
      for (int r = 0; r < tdpzp_pkg::LANES; r++) begin
         for (int c = 0; c < tdpzp_pkg::LANES; c++) begin
            prod[r][c] = tdpzp_pkg::PROD_W'(act[r]) * tdpzp_pkg::PROD_W'(wgt[c]);
         end
      end
   end

   always_comb begin
      entry.is_sum = (kind == tdpzp_pkg::KIND_SUM);
      entry.emit   = (kind == tdpzp_pkg::KIND_SLICE) && last;
      entry.slot   = sum_slot;
      entry.value  = sum_value;
      for (int r = 0; r < tdpzp_pkg::LANES; r++) begin
         for (int c = 0; c < tdpzp_pkg::LANES; c++) begin
            entry.prod[r][c] = prod[r][c];
         end
      end
   end

endmodule

[rtl/core/tdpzp_queue.sv]
// ----------------------------------------------------------------------------
// tdpzp_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tdpzp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tdpzp_pkg::entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop,
   output tdpzp_pkg::entry_type pop_entry
);

   localparam int PTR_W = $clog2(tdpzp_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tdpzp_pkg::QUEUE_DEPTH + 1);

   tdpzp_pkg::entry_type mem_ff [tdpzp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(tdpzp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/tdpzp_back.sv]
// ----------------------------------------------------------------------------
// tdpzp_back
// Accumulate slices, hold correction sums, and emit corrected result rows.
// ----------------------------------------------------------------------------
module tdpzp_back #(
   parameter int TILE_ROWS = tdpzp_pkg::DEF_ROWS,
   parameter int TILE_COLS = tdpzp_pkg::DEF_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  tdpzp_pkg::entry_type           q_entry,
   output logic                           q_pop,
   input  logic                           csr_wr_en,
   input  logic signed [tdpzp_pkg::ZP_W-1:0] csr_wr_data,
   tdpzp_rsp_if.source                    rsp_chan,
   output tdpzp_pkg::back_stat_type       stat
);

   localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
   localparam int DW    = tdpzp_pkg::DATA_W;
   localparam int NL    = tdpzp_pkg::LANES;

   logic [DW-1:0] acc_ff  [TILE_ROWS][NL];
   logic [DW-1:0] acc_in  [TILE_ROWS][NL];
   logic [DW-1:0] acc_sum [TILE_ROWS][NL];
   logic [DW-1:0] row_ff  [TILE_ROWS];
   logic [DW-1:0] row_in  [TILE_ROWS];
   logic [DW-1:0] col_ff  [NL];
   logic [DW-1:0] col_in  [NL];
   logic [DW-1:0] buf_ff  [TILE_ROWS][NL];
   logic [DW-1:0] snap_ff [TILE_ROWS];
   logic [DW-1:0] out_ff  [NL];
   logic [DW-1:0] out_in  [NL];
   logic signed [tdpzp_pkg::ZP_W-1:0] zp_ff;
   logic [ROW_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             valid_ff, valid_in;
   logic [tdpzp_pkg::ROW_IDX_W-1:0] row_idx_ff;
   logic             row_last_ff;
   logic             load;
   logic             advance;
   logic             at_end;
   logic signed [DW+tdpzp_pkg::ZP_W-1:0] corr_full;
   logic [DW-1:0]    corr;

   assign q_pop   = q_valid && (!q_entry.emit || !busy_ff);
   assign load    = q_pop && q_entry.emit;
   assign advance = busy_ff && (!valid_ff || rsp_chan.ready);
   assign at_end  = (cnt_ff == ROW_W'(TILE_ROWS - 1));

   assign stat.busy = busy_ff;
   assign stat.load = load;

   always_comb begin
      for (int r = 0; r < TILE_ROWS; r++) begin
         for (int c = 0; c < NL; c++) begin
            if (r < NL && c < TILE_COLS) begin
               acc_sum[r][c] = acc_ff[r][c] + DW'($signed(q_entry.prod[r][c]));
            end else begin
               acc_sum[r][c] = '0;
            end
            if (q_pop && !q_entry.is_sum) begin
               acc_in[r][c] = q_entry.emit ? '0 : acc_sum[r][c];
            end else begin
               acc_in[r][c] = acc_ff[r][c];
            end
         end
      end
      for (int r = 0; r < TILE_ROWS; r++) begin
         row_in[r] = row_ff[r];
         if (r < NL && q_pop && q_entry.is_sum && !q_entry.slot[2]
             && q_entry.slot[1:0] == 2'(r)) begin
            row_in[r] = q_entry.value;
         end
      end
      for (int c = 0; c < NL; c++) begin
         col_in[c] = col_ff[c];
         if (c < TILE_COLS && q_pop && q_entry.is_sum && q_entry.slot[2]
             && q_entry.slot[1:0] == 2'(c)) begin
            col_in[c] = q_entry.value;
         end
      end
   end

   assign corr_full = zp_ff * $signed(snap_ff[cnt_ff]);
   assign corr      = corr_full[DW-1:0];

   always_comb begin
      for (int c = 0; c < NL; c++) begin
         out_in[c] = (c < TILE_COLS) ? buf_ff[cnt_ff][c] - corr : '0;
      end
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (advance) begin
         cnt_in  = at_end ? '0 : cnt_ff + ROW_W'(1);
         busy_in = !at_end;
      end
      if (load) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end
      valid_in = advance || (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int r = 0; r < TILE_ROWS; r++) begin
            snap_ff[r] <= row_ff[r];
            for (int c = 0; c < NL; c++) begin
               buf_ff[r][c] <= acc_sum[r][c] + col_ff[c];
            end
         end
      end
      if (advance) begin
         out_ff      <= out_in;
         row_idx_ff  <= tdpzp_pkg::ROW_IDX_W'(cnt_ff);
         row_last_ff <= at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < TILE_ROWS; r++) begin
            row_ff[r] <= '0;
            for (int c = 0; c < NL; c++) begin
               acc_ff[r][c] <= '0;
            end
         end
         for (int c = 0; c < NL; c++) begin
            col_ff[c] <= '0;
         end
         zp_ff    <= '0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            zp_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.row_index = row_idx_ff;
   assign rsp_chan.out0      = out_ff[0];
   assign rsp_chan.out1      = out_ff[1];
   assign rsp_chan.out2      = out_ff[2];
   assign rsp_chan.out3      = out_ff[3];
   assign rsp_chan.row_last  = row_last_ff;

endmodule

[rtl/core/int8_tile_dot_product_zero_point_unit.sv]
// ----------------------------------------------------------------------------
// int8_tile_dot_product_zero_point_unit
// Quantized 4x4 tile dot product with zero-point correction.
//
// req_chan carries operand slices (kind 0: four activations, four weights)
// and correction sum loads (kind 1: one row or column sum by slot). A slice
// with last set closes the tile. rsp_chan then gives TILE_ROWS result rows,
// one per transfer, each element acc + col_sum - zero point * row_sum, the
// final row flagged by row_last. csr_wr_en/csr_wr_data write the zero point.
// Throughput: one item per cycle unless the queue is full or a closing slice
// waits on a busy row buffer; a closing slice takes TILE_ROWS transfers of the
// single result port, and the row buffer reloads only after its last row has
// moved to the output register. A closing slice reaches its first row through
// the queue, the row buffer load and the output register.
// Reset clears accumulators, sums, the zero point and the queue. When the
// receiver stalls, the output register holds, rows wait in the row buffer,
// slices keep accumulating, and req_chan.ready drops once the 4-entry queue
// fills.
// ----------------------------------------------------------------------------
module int8_tile_dot_product_zero_point_unit #(
   parameter int TILE_ROWS = tdpzp_pkg::DEF_ROWS,
   parameter int TILE_COLS = tdpzp_pkg::DEF_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   tdpzp_req_if.sink                        req_chan,
   tdpzp_rsp_if.source                      rsp_chan,
   input  logic                             csr_wr_en,
   input  logic signed [tdpzp_pkg::ZP_W-1:0] csr_wr_data
);

   logic signed [tdpzp_pkg::OPND_W-1:0] act [tdpzp_pkg::LANES];
   logic signed [tdpzp_pkg::OPND_W-1:0] wgt [tdpzp_pkg::LANES];
   tdpzp_pkg::entry_type     front_entry;
   tdpzp_pkg::entry_type     q_entry;
   tdpzp_pkg::back_stat_type back_stat;
   logic                     q_valid;
   logic                     q_pop;

   assign act[0] = req_chan.act0;
   assign act[1] = req_chan.act1;
   assign act[2] = req_chan.act2;
   assign act[3] = req_chan.act3;
   assign wgt[0] = req_chan.wgt0;
   assign wgt[1] = req_chan.wgt1;
   assign wgt[2] = req_chan.wgt2;
   assign wgt[3] = req_chan.wgt3;

   tdpzp_front u_front (
      .kind      (req_chan.kind),
      .act       (act),
      .wgt       (wgt),
      .sum_value (req_chan.sum_value),
      .sum_slot  (req_chan.sum_slot),
      .last      (req_chan.last),
      .entry     (front_entry)
   );

   tdpzp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid),
      .push_ready (req_chan.ready),
      .push_entry (front_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry)
   );

   tdpzp_back #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_chan    (rsp_chan),
      .stat        (back_stat)
   );

   a_load_starts_emit: assert property (@(posedge clock) disable iff (reset)
      back_stat.load |=> back_stat.busy)
      else $error("row buffer load did not start emission");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      back_stat.load |-> !$past(back_stat.load) || !back_stat.busy)
      else $error("row buffer reloaded while emitting");

   a_row_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.row_last |=>
         rsp_chan.valid && rsp_chan.row_index == $past(rsp_chan.row_index) + 2'd1)
      else $error("result rows out of sequence");

   a_tile_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.row_last |=>
         !rsp_chan.valid || rsp_chan.row_index == 2'd0)
      else $error("new tile did not start at row zero");

endmodule

[verif/int8_tile_dot_product_zero_point_unit_tb.sv]
// ----------------------------------------------------------------------------
// int8_tile_dot_product_zero_point_unit_tb
// Self-checking bench for the 4x4 quantized tile dot product unit.
//
// Streams correction sum loads and operand slices into req_chan. A scoreboard
// keeps its own accumulators, sums and zero point, and predicts the four
// result rows of every closing slice. Each row taken from rsp_chan is checked
// field by field against the oldest prediction. Both channels idle at random,
// the receiver holds off once long enough to back up the input queue, and
// the zero point is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module int8_tile_dot_product_zero_point_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT     = 1000000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE    = 8;
   localparam int PHASE_LEN = 92;
   localparam int SLICE_W   = 4 * tdpzp_pkg::OPND_W;

   typedef struct {
      logic                                kind;
      logic signed [tdpzp_pkg::OPND_W-1:0] act [tdpzp_pkg::LANES];
      logic signed [tdpzp_pkg::OPND_W-1:0] wgt [tdpzp_pkg::LANES];
      logic [tdpzp_pkg::DATA_W-1:0]        sum_value;
      logic [tdpzp_pkg::SLOT_W-1:0]        sum_slot;
      logic                                last;
   } tile_item_type;

   typedef struct {
      logic [tdpzp_pkg::ROW_IDX_W-1:0] row_index;
      logic [tdpzp_pkg::DATA_W-1:0]    outv [tdpzp_pkg::LANES];
      logic                            row_last;
   } row_result_type;

   class tile_scoreboard_type;
      logic signed [tdpzp_pkg::ZP_W-1:0] zp_value;
      bit [tdpzp_pkg::DATA_W-1:0] acc [tdpzp_pkg::DEF_ROWS][tdpzp_pkg::DEF_COLS];
      bit [tdpzp_pkg::DATA_W-1:0] row_sums [tdpzp_pkg::DEF_ROWS];
      bit [tdpzp_pkg::DATA_W-1:0] col_sums [tdpzp_pkg::DEF_COLS];
      row_result_type             expected_rows [$];
      int                         errors;

      function new();
         zp_value = '0;
         errors = 0;
         foreach (acc[r, c]) acc[r][c] = '0;
         foreach (row_sums[r]) row_sums[r] = '0;
         foreach (col_sums[c]) col_sums[c] = '0;
      endfunction

      function void note_transfer(tile_item_type it);
         bit [tdpzp_pkg::DATA_W-1:0] corr;
         row_result_type             expected;
         if (it.kind == tdpzp_pkg::KIND_SUM) begin
            if (it.sum_slot < tdpzp_pkg::LANES)
               row_sums[it.sum_slot[1:0]] = it.sum_value;
            else
               col_sums[it.sum_slot[1:0]] = it.sum_value;
            return;
         end
         for (int r = 0; r < tdpzp_pkg::DEF_ROWS; r++)
            for (int c = 0; c < tdpzp_pkg::DEF_COLS; c++)
               acc[r][c] += tdpzp_pkg::DATA_W'(int'(it.act[r]) * int'(it.wgt[c]));
         if (!it.last)
            return;
         for (int r = 0; r < tdpzp_pkg::DEF_ROWS; r++) begin
            corr = tdpzp_pkg::DATA_W'(int'(zp_value) * int'(row_sums[r]));
            expected.row_index = tdpzp_pkg::ROW_IDX_W'(r);
            for (int c = 0; c < tdpzp_pkg::LANES; c++)
               expected.outv[c] = (c < tdpzp_pkg::DEF_COLS) ?
                                  acc[r][c] + col_sums[c] - corr : '0;
            expected.row_last = (r == tdpzp_pkg::DEF_ROWS - 1);
            expected_rows.push_back(expected);
         end
         foreach (acc[r, c]) acc[r][c] = '0;
      endfunction

      function void check_row(row_result_type got);
         row_result_type expected;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row %0d, expected none", $time, got.row_index);
            errors++;
            return;
         end
         expected = expected_rows.pop_front();
         if (got.row_index !== expected.row_index) begin
            $display("%0t: row_index expected %0d actual %0d",
                     $time, expected.row_index, got.row_index);
            errors++;
         end
         for (int c = 0; c < tdpzp_pkg::LANES; c++)
            if (got.outv[c] !== expected.outv[c]) begin
               $display("%0t: row %0d out%0d expected %h actual %h",
                        $time, expected.row_index, c, expected.outv[c], got.outv[c]);
               errors++;
            end
         if (got.row_last !== expected.row_last) begin
            $display("%0t: row %0d row_last expected %b actual %b",
                     $time, expected.row_index, expected.row_last, got.row_last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_wr_en = 1'b0;
   logic signed [tdpzp_pkg::ZP_W-1:0] csr_wr_data = '0;

   tdpzp_req_if req_chan ();
   tdpzp_rsp_if rsp_chan ();

   int8_tile_dot_product_zero_point_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   tile_scoreboard_type sb;
   tile_item_type       seen_item;
   row_result_type      seen_row;
   int                  cycle_count = 0;
   int                  items_sent = 0;
   bit                  hold_pending = 1'b0;
   bit                  burst_mode = 1'b0;
   bit                  sender_steady = 1'b0;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_item.kind = req_chan.kind;
            seen_item.act[0] = req_chan.act0;
            seen_item.act[1] = req_chan.act1;
            seen_item.act[2] = req_chan.act2;
            seen_item.act[3] = req_chan.act3;
            seen_item.wgt[0] = req_chan.wgt0;
            seen_item.wgt[1] = req_chan.wgt1;
            seen_item.wgt[2] = req_chan.wgt2;
            seen_item.wgt[3] = req_chan.wgt3;
            seen_item.sum_value = req_chan.sum_value;
            seen_item.sum_slot = req_chan.sum_slot;
            seen_item.last = req_chan.last;
            sb.note_transfer(seen_item);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_row.row_index = rsp_chan.row_index;
            seen_row.outv[0] = rsp_chan.out0;
            seen_row.outv[1] = rsp_chan.out1;
            seen_row.outv[2] = rsp_chan.out2;
            seen_row.outv[3] = rsp_chan.out3;
            seen_row.row_last = rsp_chan.row_last;
            sb.check_row(seen_row);
         end
      end
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14)
         return $urandom_range(1, 2);
      if (pick < 19)
         return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   function automatic int offer_gap();
      if (burst_mode || sender_steady || $urandom_range(0, 1) == 0)
         return 0;
      return idle_length();
   endfunction

   initial begin : rsp_sink
      int stall_left;
      bit quiet;
      stall_left = 0;
      quiet = 1'b0;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0)
            quiet = !quiet;
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
               stall_left = idle_length();
         end
      end
   end

   function automatic tile_item_type make_slice(logic [SLICE_W-1:0] acts,
                                                logic [SLICE_W-1:0] wgts, bit last);
      tile_item_type it;
      it.kind = tdpzp_pkg::KIND_SLICE;
      for (int i = 0; i < tdpzp_pkg::LANES; i++) begin
         it.act[i] = acts[tdpzp_pkg::OPND_W*i +: tdpzp_pkg::OPND_W];
         it.wgt[i] = wgts[tdpzp_pkg::OPND_W*i +: tdpzp_pkg::OPND_W];
      end
      it.sum_value = $urandom();
      it.sum_slot = tdpzp_pkg::SLOT_W'($urandom_range(0, 7));
      it.last = last;
      return it;
   endfunction

   function automatic tile_item_type make_sum(int slot, logic [tdpzp_pkg::DATA_W-1:0] value,
                                              bit last);
      tile_item_type it;
      it = make_slice(SLICE_W'($urandom()), SLICE_W'($urandom()), last);
      it.kind = tdpzp_pkg::KIND_SUM;
      it.sum_slot = tdpzp_pkg::SLOT_W'(slot);
      it.sum_value = value;
      return it;
   endfunction

   function automatic tile_item_type random_slice(bit last);
      logic [SLICE_W-1:0] acts, wgts;
      acts = SLICE_W'($urandom());
      wgts = SLICE_W'($urandom());
      if ($urandom_range(0, 7) == 0)
         for (int i = 0; i < tdpzp_pkg::LANES; i++) begin
            acts[tdpzp_pkg::OPND_W*i +: tdpzp_pkg::OPND_W] =
               $urandom_range(0, 1) ? 7'h3f : 7'h40;
            wgts[tdpzp_pkg::OPND_W*i +: tdpzp_pkg::OPND_W] =
               $urandom_range(0, 1) ? 7'h3f : 7'h40;
         end
      return make_slice(acts, wgts, last);
   endfunction

   function automatic tile_item_type random_sum();
      logic [tdpzp_pkg::DATA_W-1:0] value;
      case ($urandom_range(0, 7))
         0: value = 32'h7fff_ffff;
         1: value = 32'h8000_0000;
         default: value = $urandom();
      endcase
      return make_sum(int'($urandom_range(0, 7)), value, 1'($urandom_range(0, 1)));
   endfunction

   task automatic send_item(input tile_item_type it, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.kind <= it.kind;
      req_chan.act0 <= it.act[0];
      req_chan.act1 <= it.act[1];
      req_chan.act2 <= it.act[2];
      req_chan.act3 <= it.act[3];
      req_chan.wgt0 <= it.wgt[0];
      req_chan.wgt1 <= it.wgt[1];
      req_chan.wgt2 <= it.wgt[2];
      req_chan.wgt3 <= it.wgt[3];
      req_chan.sum_value <= it.sum_value;
      req_chan.sum_slot <= it.sum_slot;
      req_chan.last <= it.last;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_zp_reg(input logic signed [tdpzp_pkg::ZP_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.zp_value = value;
      @(negedge clock);
   endtask

   task automatic send_random_tile();
      int depth;
      sender_steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) send_item(random_sum(), offer_gap());
      depth = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < depth; k++) begin
         if ($urandom_range(0, 15) == 0)
            send_item(random_sum(), offer_gap());
         send_item(random_slice(k == depth - 1), offer_gap());
      end
   endtask

   initial begin : stimulus
      logic signed [tdpzp_pkg::ZP_W-1:0] zp_plan [5];
      int phase_end;
      req_chan.valid = 1'b0;
      req_chan.kind = tdpzp_pkg::KIND_SLICE;
      req_chan.act0 = '0;
      req_chan.act1 = '0;
      req_chan.act2 = '0;
      req_chan.act3 = '0;
      req_chan.wgt0 = '0;
      req_chan.wgt1 = '0;
      req_chan.wgt2 = '0;
      req_chan.wgt3 = '0;
      req_chan.sum_value = '0;
      req_chan.sum_slot = '0;
      req_chan.last = 1'b0;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_zp_reg(-8'sd128);
      send_item(make_sum(0, 32'h7fff_ffff, 1'b0), 0);
      send_item(make_sum(1, 32'h8000_0000, 1'b0), 0);
      send_item(make_sum(2, 32'hffff_ffff, 1'b1), offer_gap());
      send_item(make_sum(3, 32'h0000_0001, 1'b0), 0);
      send_item(make_sum(4, 32'h8000_0000, 1'b0), 0);
      send_item(make_sum(5, 32'h7fff_ffff, 1'b1), offer_gap());
      send_item(make_sum(6, 32'hffff_ffff, 1'b0), 0);
      send_item(make_sum(7, 32'h0000_abcd, 1'b0), 0);
      send_item(make_slice({4{7'h40}}, {4{7'h40}}, 1'b0), 0);
      send_item(make_slice({4{7'h3f}}, {4{7'h40}}, 1'b0), offer_gap());
      send_item(make_slice({7'h7f, 7'h00, 7'h3f, 7'h40},
                           {7'h01, 7'h7f, 7'h40, 7'h3f}, 1'b1), 0);
      send_item(make_slice({4{7'h3f}}, {4{7'h3f}}, 1'b1), 0);
      drain_pipeline();

      write_zp_reg(8'sd127);
      send_item(make_slice({4{7'h00}}, {4{7'h00}}, 1'b1), 0);
      send_item(make_sum(0, 32'h0000_0000, 1'b0), 0);
      send_item(make_slice({7'h40, 7'h3f, 7'h40, 7'h3f},
                           {7'h3f, 7'h40, 7'h3f, 7'h40}, 1'b1), 0);
      send_item(random_slice(1'b1), 0);
      drain_pipeline();

      zp_plan[0] = 8'sd0;
      zp_plan[1] = tdpzp_pkg::ZP_W'($urandom_range(0, 255));
      zp_plan[2] = 8'sd127;
      zp_plan[3] = tdpzp_pkg::ZP_W'($urandom_range(0, 255));
      zp_plan[4] = -8'sd128;
      foreach (zp_plan[phase]) begin
         write_zp_reg(zp_plan[phase]);
         phase_end = items_sent + PHASE_LEN;
         if (phase == 1) begin
            burst_mode = 1'b1;
            hold_pending = 1'b1;
         end
         while (items_sent < phase_end)
            send_random_tile();
         burst_mode = 1'b0;
         drain_pipeline();
      end

      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
rtl/core/tdpzp_pkg.sv
rtl/core/tdpzp_if.sv
rtl/core/tdpzp_front.sv
rtl/core/tdpzp_queue.sv
rtl/core/tdpzp_back.sv
rtl/core/int8_tile_dot_product_zero_point_unit.sv
verif/int8_tile_dot_product_zero_point_unit_tb.sv
